// File: src/sha1bsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher package
// Request and result types, request kinds, status codes, SHA-1 constants and
// the sequencer state type.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

	typedef logic [1:0] kind_t;
	typedef logic [1:0] status_t;

	localparam kind_t KIND_BYTE    = 2'd0;
	localparam kind_t KIND_FINISH  = 2'd1;
	localparam kind_t KIND_RESTART = 2'd2;

	localparam status_t STAT_OK           = 2'd0;
	localparam status_t STAT_TOO_LONG     = 2'd1;
	localparam status_t STAT_AFTER_FINISH = 2'd2;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		status_t     status;
		logic        last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMP,
		ST_ADD,
		ST_EMIT,
		ST_ERR
	} state_t;

	localparam logic [31:0] SHA1_IV [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] BLOCK_LAST = 6'd63;
	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] R1_START   = 7'd20;
	localparam logic [6:0] R2_START   = 7'd40;
	localparam logic [6:0] R3_START   = 7'd60;
	localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

// File: src/sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// Message bytes shift into a 16-word block register; one shared round unit
// runs the 80 SHA-1 rounds on each full block; a finish returns the digest.
// ----------------------------------------------------------------------------
// A message byte that does not complete a block leaves the request side ready.
// The byte that completes a 64-byte block starts a compression: the 80 rounds
// run in turn through the single round unit, then the chaining add. A first
// finish shifts padding and the length into the block one byte per cycle,
// runs one or two compressions, then hands out the five digest words at one
// per cycle as the result side takes them. A repeated finish or an error
// finish goes straight to the output. The request side is not ready while
// the block pads, compresses or hands out results.
module sha1_byte_stream_hasher (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sha1bsh_pkg::in_item_t  in_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sha1bsh_pkg::out_item_t out_item
);
	import sha1bsh_pkg::*;

	state_t      state_q, state_d;
	logic [31:0] chain_q [5];
	logic [31:0] w_q [16];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic [5:0]  fill_q;
	logic [60:0] cnt_q;
	logic        finished_q;
	status_t     err_q;
	logic        pad_q;
	logic        final_q;
	logic [2:0]  idx_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        in_acc;
	logic        out_free;
	logic        shift_en;
	logic [7:0]  shift_byte;
	logic        comp_start;
	logic        byte_acc;
	logic        pad_start;
	logic        restart;
	logic        set_state_err;
	logic        out_load;
	out_item_t   out_d;

	logic [63:0] len_bits;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] w_new;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign len_bits = {cnt_q, 3'b000};
	assign len_sel  = 3'd7 - fill_q[2:0];
	assign len_byte = len_bits[{len_sel, 3'b000} +: 8];

	always_comb begin
		if (rnd_q < R1_START) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_R0;
		end else if (rnd_q < R2_START) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R1;
		end else if (rnd_q < R3_START) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_R2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_R3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w_q[0] + k_val;
	assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		shift_en      = 1'b0;
		shift_byte    = in_item.data_byte;
		comp_start    = 1'b0;
		byte_acc      = 1'b0;
		pad_start     = 1'b0;
		restart       = 1'b0;
		set_state_err = 1'b0;
		out_load      = 1'b0;
		out_d         = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (in_item.kind)
						KIND_BYTE: begin
							if (finished_q) begin
								set_state_err = 1'b1;
							end else if (err_q == STAT_OK) begin
								shift_en = 1'b1;
								byte_acc = 1'b1;
								if (fill_q == BLOCK_LAST) begin
									state_d    = ST_COMP;
									comp_start = 1'b1;
								end
							end
						end
						KIND_FINISH: begin
							if (err_q != STAT_OK) begin
								state_d = ST_ERR;
							end else if (finished_q) begin
								state_d = ST_EMIT;
							end else begin
								shift_en   = 1'b1;
								shift_byte = PAD_MARK;
								pad_start  = 1'b1;
								if (fill_q == BLOCK_LAST) begin
									state_d    = ST_COMP;
									comp_start = 1'b1;
								end else begin
									state_d = ST_PAD;
								end
							end
						end
						KIND_RESTART: begin
							restart = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ST_PAD: begin
				shift_en   = 1'b1;
				shift_byte = (final_q && fill_q >= LEN_POS) ? len_byte : 8'h00;
				if (fill_q == BLOCK_LAST) begin
					state_d    = ST_COMP;
					comp_start = 1'b1;
				end
			end
			ST_COMP: begin
				if (rnd_q == LAST_ROUND) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (!pad_q) begin
					state_d = ST_IDLE;
				end else if (!final_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load          = 1'b1;
					out_d.digest_word = chain_q[idx_q];
					out_d.word_index  = idx_q;
					out_d.status      = STAT_OK;
					out_d.last        = (idx_q == LAST_WORD);
					if (idx_q == LAST_WORD) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_ERR: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_d.status = err_q;
					out_d.last   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 5; i++) begin
				chain_q[i] <= SHA1_IV[i];
			end
			fill_q      <= '0;
			cnt_q       <= '0;
			finished_q  <= 1'b0;
			err_q       <= STAT_OK;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
			idx_q       <= '0;
			rnd_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (restart) begin
				for (int i = 0; i < 5; i++) begin
					chain_q[i] <= SHA1_IV[i];
				end
				fill_q     <= '0;
				cnt_q      <= '0;
				finished_q <= 1'b0;
				err_q      <= STAT_OK;
			end
			if (set_state_err) begin
				err_q <= STAT_AFTER_FINISH;
			end
			if (shift_en) begin
				fill_q <= fill_q + 6'd1;
			end
			if (byte_acc) begin
				cnt_q <= cnt_q + 61'd1;
				if (&cnt_q) begin
					err_q <= STAT_TOO_LONG;
				end
			end
			if (pad_start) begin
				pad_q   <= 1'b1;
				final_q <= (fill_q < LEN_POS);
			end
			if (comp_start) begin
				rnd_q <= '0;
			end else if (state_q == ST_COMP) begin
				rnd_q <= rnd_q + 7'd1;
			end
			if (state_q == ST_ADD) begin
				chain_q[0] <= chain_q[0] + a_q;
				chain_q[1] <= chain_q[1] + b_q;
				chain_q[2] <= chain_q[2] + c_q;
				chain_q[3] <= chain_q[3] + d_q;
				chain_q[4] <= chain_q[4] + e_q;
				if (pad_q && !final_q) begin
					final_q <= 1'b1;
				end else if (pad_q) begin
					pad_q      <= 1'b0;
					finished_q <= 1'b1;
					cnt_q      <= '0;
				end
			end
			if (out_load) begin
				idx_q <= (idx_q == LAST_WORD || state_q == ST_ERR) ? 3'd0 : idx_q + 3'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// block register, round unit and result payload
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			end
			w_q[15] <= {w_q[15][23:0], shift_byte};
		end else if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
		end
		if (comp_start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == ST_COMP) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	a_rnd_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMP |-> rnd_q <= LAST_ROUND)
		else $error("round counter out of range");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> idx_q <= LAST_WORD)
		else $error("digest word index out of range");

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != STAT_OK |->
		out_q.last && out_q.digest_word == 32'd0 && out_q.word_index == 3'd0)
		else $error("error result malformed");

	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == STAT_OK |-> out_q.last == (out_q.word_index == LAST_WORD))
		else $error("last mark on wrong digest word");

	a_finish_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && finished_q |-> fill_q == 6'd0 && cnt_q == 61'd0)
		else $error("stale fill state after finish");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> err_q == STAT_OK && !finished_q && fill_q == 6'd0)
		else $error("restart did not clear state");

endmodule

// File: sim/sha1_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Drives byte, finish, restart and unused requests with random gaps on both
// sides. A cycle-free SHA-1 predictor builds the expected digest words, and
// every returned word is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_tb;

	import sha1bsh_pkg::*;

	localparam kind_t KIND_UNUSED     = 2'd3;
	localparam int    HOLD_CYCLES     = 400;
	localparam int    WATCHDOG_LIMIT  = 5000;
	localparam int    DRAIN_CYCLES    = 300;
	localparam int    BOUNDARY_LENGTHS [6] = '{55, 56, 57, 63, 64, 119};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// predictor state
	logic [31:0] hash_words [5];
	logic [7:0]  block_buf [64];
	logic [6:0]  block_fill;
	logic [63:0] message_bits;
	logic        digest_ready;
	status_t     error_status;

	out_item_t expected_digests [$];

	int mismatches = 0;
	int requests_sent = 0;
	int words_checked = 0;
	int error_results = 0;
	int idle_cycles = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int stall_requests = 0;
	int stalls_done = 0;

	sha1_byte_stream_hasher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] rotl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic void compress_block_buf();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (int i = 16; i < 80; i++)
			w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
		a = hash_words[0];
		b = hash_words[1];
		c = hash_words[2];
		d = hash_words[3];
		e = hash_words[4];
		for (int i = 0; i < 80; i++) begin
			if (i < int'(R1_START)) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (i < int'(R2_START)) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (i < int'(R3_START)) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = rotl(a, 5) + f + e + w[i] + k;
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hash_words[0] += a;
		hash_words[1] += b;
		hash_words[2] += c;
		hash_words[3] += d;
		hash_words[4] += e;
		block_fill = '0;
	endfunction

	function automatic void pad_message();
		int pos;
		pos = int'(block_fill[5:0]);
		block_buf[pos] = PAD_MARK;
		pos++;
		if (pos > int'(LEN_POS)) begin
			while (pos < 64) begin
				block_buf[pos] = 8'h00;
				pos++;
			end
			compress_block_buf();
			pos = 0;
		end
		while (pos < int'(LEN_POS)) begin
			block_buf[pos] = 8'h00;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			block_buf[int'(LEN_POS) + i] = message_bits[63 - 8*i -: 8];
		compress_block_buf();
		foreach (block_buf[i])
			block_buf[i] = 8'h00;
		message_bits = '0;
		digest_ready = 1'b1;
	endfunction

	function automatic void restart_model();
		foreach (hash_words[i])
			hash_words[i] = SHA1_IV[i];
		block_fill = '0;
		message_bits = '0;
		digest_ready = 1'b0;
		error_status = STAT_OK;
	endfunction

	function automatic void predict_request(in_item_t req);
		out_item_t res;
		case (req.kind)
			KIND_BYTE: begin
				if (digest_ready) begin
					error_status = STAT_AFTER_FINISH;
				end else if (error_status == STAT_OK) begin
					block_buf[block_fill[5:0]] = req.data_byte;
					block_fill = block_fill + 7'd1;
					message_bits += 64'd8;
					if (message_bits == '0)
						error_status = STAT_TOO_LONG;
					if (block_fill >= 7'd64)
						compress_block_buf();
				end
			end
			KIND_FINISH: begin
				if (error_status != STAT_OK) begin
					res = '{digest_word: '0, word_index: '0, status: error_status, last: 1'b1};
					expected_digests.push_back(res);
				end else begin
					if (!digest_ready)
						pad_message();
					for (int i = 0; i < 5; i++) begin
						res = '{digest_word: hash_words[i], word_index: 3'(i), status: STAT_OK,
							last: (3'(i) == LAST_WORD)};
						expected_digests.push_back(res);
					end
				end
			end
			KIND_RESTART: restart_model();
			default: ;
		endcase
	endfunction

	function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
		end
	endfunction

	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) != 0)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	function automatic int pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return $urandom_range(8, 0);
		if (r < 80)
			return $urandom_range(40, 9);
		return BOUNDARY_LENGTHS[$urandom_range(5)];
	endfunction

	// check results, then advance the predictor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_digests.size() == 0) begin
					mismatches++;
					$display("%0t: result with nothing expected, got %h", $time, out_item);
				end else begin
					want = expected_digests.pop_front();
					report_field("digest_word", want.digest_word, out_item.digest_word);
					report_field("word_index", 32'(want.word_index), 32'(out_item.word_index));
					report_field("status", 32'(want.status), 32'(out_item.status));
					report_field("last", 32'(want.last), 32'(out_item.last));
					words_checked++;
					if (want.status != STAT_OK)
						error_results++;
				end
			end
			if (in_valid && in_ready)
				predict_request(in_item);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// result side: random gaps, plus long holds on demand
	initial begin
		int gap;
		forever begin
			@(negedge clk);
			if (stall_requests != stalls_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				stalls_done++;
			end else begin
				gap = pick_gap(sink_idle_pct);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	task automatic send_request(kind_t kind, logic [7:0] data_byte);
		int gap;
		gap = pick_gap(src_idle_pct);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_item <= '{kind: kind, data_byte: data_byte};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (kind != KIND_UNUSED)
			requests_sent++;
	endtask

	task automatic test_directed();
		src_idle_pct = 30;
		sink_idle_pct = 30;
		send_request(KIND_FINISH, 8'h00);
		send_request(KIND_FINISH, 8'hFF);
		send_request(KIND_BYTE, 8'hFF);
		send_request(KIND_FINISH, 8'h00);
		send_request(KIND_UNUSED, 8'hFF);
		send_request(KIND_RESTART, 8'h00);
		send_request(KIND_BYTE, 8'h61);
		send_request(KIND_BYTE, 8'h62);
		send_request(KIND_BYTE, 8'h63);
		send_request(KIND_UNUSED, 8'h00);
		send_request(KIND_BYTE, 8'h00);
		send_request(KIND_BYTE, 8'hFF);
		send_request(KIND_FINISH, 8'hA5);
		send_request(KIND_RESTART, 8'h5A);
		send_request(KIND_BYTE, 8'h00);
		send_request(KIND_FINISH, 8'hFF);
		send_request(KIND_FINISH, 8'h00);
	endtask

	task automatic test_random_messages(int n_requests);
		int goal;
		int len;
		goal = requests_sent + n_requests;
		while (requests_sent < goal) begin
			src_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
			sink_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
			if ($urandom_range(9) != 0)
				send_request(KIND_RESTART, 8'($urandom));
			len = pick_length();
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(19) == 0)
					send_request(KIND_UNUSED, 8'($urandom));
				if ($urandom_range(99) == 0)
					send_request(KIND_RESTART, 8'($urandom));
				send_request(KIND_BYTE, 8'($urandom));
			end
			send_request(KIND_FINISH, 8'($urandom));
			if ($urandom_range(3) == 0)
				send_request(KIND_FINISH, 8'($urandom));
		end
	endtask

	task automatic test_full_rate();
		int len;
		src_idle_pct = 0;
		sink_idle_pct = 0;
		for (int m = 0; m < 3; m++) begin
			send_request(KIND_RESTART, 8'($urandom));
			len = pick_length();
			for (int i = 0; i < len; i++)
				send_request(KIND_BYTE, 8'($urandom));
			send_request(KIND_FINISH, 8'($urandom));
		end
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		stall_requests++;
		send_request(KIND_RESTART, 8'($urandom));
		for (int i = 0; i < 8; i++)
			send_request(KIND_BYTE, 8'($urandom));
		send_request(KIND_FINISH, 8'($urandom));
		send_request(KIND_RESTART, 8'($urandom));
		for (int i = 0; i < 3; i++)
			send_request(KIND_BYTE, 8'($urandom));
		send_request(KIND_FINISH, 8'($urandom));
		send_request(KIND_FINISH, 8'($urandom));
	endtask

	task automatic finish_run();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_digests.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		foreach (block_buf[i])
			block_buf[i] = 8'h00;
		restart_model();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_full_rate();
		test_backpressure();
		test_random_messages(280);
		finish_run();
		$display("Run covered %0d requests and %0d returned words, %0d of them error status.",
			requests_sent, words_checked, error_results);
		$display("Padding edges, repeated finish, restart and a long result hold were included.");
		if (mismatches == 0 && expected_digests.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
